FILE: design/fbpa_pkg.sv
// Shared types, constants and helpers of the fixed block pool allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fbpa_pkg;

  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned CHUNK_W    = 17;
  localparam int unsigned OFS_W      = 24;

  localparam logic [CNT_W-1:0]   HEAD_EMPTY        = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0]   BLOCK_COUNT_RESET = CNT_W'(256);
  localparam logic [CHUNK_W-1:0] CHUNK_BYTES_RESET = CHUNK_W'(1024);

  // request kinds
  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // register indexes (paddr[2])
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_CHUNK_BYTES = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] block_in;
  } in_item_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] block_out;
    logic [OFS_W-1:0] byte_offset;
    logic [CNT_W-1:0] free_left;
    logic             overflow_error;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } fbpa_state_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } fbpa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_blocked;
  } fbpa_sts_t;

  // effective block count: zero counts as one, clamp to pool size
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > HEAD_EMPTY) begin
      r = HEAD_EMPTY;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: design/fbpa_ctrl.sv
// Sequencing FSM of the block pool allocator: accept, then execute and commit.
// Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fbpa_pkg::fbpa_sts_t sts_i,
  output fbpa_pkg::fbpa_cmd_t cmd_o
);
  import fbpa_pkg::*;

  fbpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // link read is back; commit once the output register has room
        if (!sts_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: design/fbpa_dp.sv
// Datapath of the block pool allocator: link memory, head/fresh/free counters,
// offset multiply and output register. Depends on fbpa_pkg.
`timescale 1ns / 1ps

module fbpa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbpa_pkg::fbpa_cmd_t           cmd_i,
  output fbpa_pkg::fbpa_sts_t           sts_o,
  input  fbpa_pkg::in_item_t            in_item_i,
  input  logic                          cfg_init_i,
  input  logic [fbpa_pkg::CNT_W-1:0]    eff_count_i,
  input  logic [fbpa_pkg::CHUNK_W-1:0]  chunk_bytes_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fbpa_pkg::out_item_t           out_item_o
);
  import fbpa_pkg::*;

  logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] link_rd_q;

  in_item_t         req_q;
  logic [CNT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] fresh_q, fresh_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic             out_valid_q;
  out_item_t        out_item_q, out_item_d;

  logic                   head_empty;
  logic [CNT_W-1:0]       unused, list_len;
  logic                   grant, ovf, link_we;
  logic [IDX_W-1:0]       idx, link_wdata;
  logic [IDX_W+CHUNK_W-1:0] product;

  // link memory: read at the current head every cycle, written on release
  always_ff @(posedge clk_i) begin
    link_rd_q <= link_mem[head_q[IDX_W-1:0]];
    if (cmd_i.commit && link_we) begin
      link_mem[req_q.block_in] <= link_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_item_i;
    end
    if (cmd_i.commit) begin
      out_item_q <= out_item_d;
    end
  end

  always_comb begin
    head_empty = head_q[IDX_W];
    unused     = (eff_count_i > fresh_q) ? eff_count_i - fresh_q : '0;
    list_len   = (free_q > unused) ? free_q - unused : '0;

    head_d     = head_q;
    fresh_d    = fresh_q;
    free_d     = free_q;
    grant      = 1'b0;
    ovf        = 1'b0;
    idx        = '0;
    link_we    = 1'b0;
    link_wdata = head_empty ? '0 : head_q[IDX_W-1:0];

    if (req_q.kind == KIND_ALLOC) begin
      priority if (!head_empty) begin
        idx    = head_q[IDX_W-1:0];
        grant  = 1'b1;
        // last list entry has no valid link behind it
        head_d = (list_len >= CNT_W'(2)) ? {1'b0, link_rd_q} : HEAD_EMPTY;
      end else if (fresh_q < eff_count_i) begin
        idx     = fresh_q[IDX_W-1:0];
        grant   = 1'b1;
        fresh_d = fresh_q + CNT_W'(1);
      end
      if (grant && free_q != '0) begin
        free_d = free_q - CNT_W'(1);
      end
    end else begin
      priority if (free_q >= eff_count_i) begin
        ovf = 1'b1;
      end else if ({1'b0, req_q.block_in} < eff_count_i) begin
        link_we = 1'b1;
        head_d  = {1'b0, req_q.block_in};
        free_d  = free_q + CNT_W'(1);
      end
    end

    product                   = idx * chunk_bytes_i;
    out_item_d.granted        = grant;
    out_item_d.block_out      = grant ? idx : '0;
    out_item_d.byte_offset    = grant ? product[OFS_W-1:0] : '0;
    out_item_d.free_left      = free_d;
    out_item_d.overflow_error = ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= HEAD_EMPTY;
      fresh_q     <= '0;
      free_q      <= CNT_W'(MAX_BLOCKS);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_init_i) begin
        head_q  <= HEAD_EMPTY;
        fresh_q <= '0;
        free_q  <= eff_count_i;
      end else if (cmd_i.commit) begin
        head_q  <= head_d;
        fresh_q <= fresh_d;
        free_q  <= free_d;
      end
      out_valid_q <= cmd_i.commit || (out_valid_q && out_stall_i);
    end
  end

  assign sts_o.out_blocked = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;

  // the checks below skip the rebuild cycle, where the count is already the new one

  // free blocks never exceed the pool
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_init_i |-> free_q <= eff_count_i)
    else $error("free count above block count");

  // never-used cursor stays inside the pool
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_init_i |-> fresh_q <= eff_count_i)
    else $error("fresh cursor beyond block count");

  // a non-empty head implies at least one listed block
  a_head_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_init_i && !head_q[IDX_W] |-> list_len != '0)
    else $error("free list head set with empty list");

endmodule

FILE: design/fixed_block_pool_allocator_top.sv
// Top level of the fixed block pool allocator: APB registers, controller and
// datapath. Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
`timescale 1ns / 1ps

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_item_i  (kind, block_in)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (granted, ...)
//  cfg     | input     | APB psel/penable/pready   | 0x0 block_count, 0x4 chunk_bytes
//
// Each request is accepted in ST_IDLE, which also reads the link memory at the
// free-list head (registered read); ST_EXEC then updates head/counters and loads
// the output register. The next request depends on the updated head.
// Reset empties the free list, block_count = 256, chunk_bytes = 1024.
// Writing block_count re-creates the pool; no clearing pass is needed.
// A stalled output holds its item; one new request may still be accepted.

module fixed_block_pool_allocator_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fbpa_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fbpa_pkg::out_item_t  out_item_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import fbpa_pkg::*;

  logic [CNT_W-1:0]   block_count_q;
  logic [CHUNK_W-1:0] chunk_bytes_q;
  logic               cfg_we;
  logic               cfg_init;
  fbpa_cmd_t          cmd;
  fbpa_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  // block_count write also rebuilds the pool state
  assign cfg_init = cfg_we && (paddr[2] == REG_BLOCK_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BLOCK_COUNT_RESET;
      chunk_bytes_q <= CHUNK_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_BLOCK_COUNT: block_count_q <= pwdata[CNT_W-1:0];
        REG_CHUNK_BYTES: chunk_bytes_q <= pwdata[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_COUNT: prdata = {{(32-CNT_W){1'b0}}, block_count_q};
      REG_CHUNK_BYTES: prdata = {{(32-CHUNK_W){1'b0}}, chunk_bytes_q};
      default:         prdata = '0;
    endcase
  end

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // effective count is taken from the register; on a block_count write the
  // datapath reloads from the value being written
  fbpa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_item_i     (in_item_i),
    .cfg_init_i    (cfg_init),
    .eff_count_i   (cfg_init ? eff_count(pwdata[CNT_W-1:0]) : eff_count(block_count_q)),
    .chunk_bytes_i (chunk_bytes_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

FILE: tb/tb_fixed_block_pool_allocator_top.sv
// Self-checking testbench for fixed_block_pool_allocator_top: a cycle-free pool model
// predicts every response, and a monitor compares each one field by field.
// Depends on fbpa_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_top;
  import fbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int unsigned SETTLE      = 4;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fixed_block_pool_allocator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool model: registers, free-list links, head, never-used mark, free count
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]   cfg_blocks;
  logic [CHUNK_W-1:0] cfg_chunk;
  logic [IDX_W-1:0]   next_link [MAX_BLOCKS];
  logic [CNT_W-1:0]   pool_head;
  logic [CNT_W-1:0]   pool_fresh;
  logic [CNT_W-1:0]   pool_free;

  out_item_t        resp_due [$];   // responses still to come, oldest first
  logic [IDX_W-1:0] held [$];       // blocks handed out, used to build legal releases

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          steady = 1'b0;       // no idling on either side
  bit          long_hold = 1'b0;    // receiver holds off for HOLD_CYCLES

  // zero counts as one block, anything past the pool size is clamped
  function automatic logic [CNT_W-1:0] usable_blocks();
    if (cfg_blocks == '0) return CNT_W'(1);
    if (cfg_blocks > HEAD_EMPTY) return HEAD_EMPTY;
    return cfg_blocks;
  endfunction

  // re-create the pool: empty list, nothing used yet; links keep stale contents
  function automatic void pool_rebuild();
    pool_head  = HEAD_EMPTY;
    pool_fresh = '0;
    pool_free  = usable_blocks();
  endfunction

  // Advances the pool model by one request and returns the response it owes.
  function automatic out_item_t alloc_predict(input in_item_t req);
    out_item_t        r;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] unused;
    logic [CNT_W-1:0] listed;
    logic [CNT_W-1:0] idx;
    logic [31:0]      ofs;
    n   = usable_blocks();
    r   = '0;
    idx = '0;
    if (req.kind == KIND_ALLOC) begin
      // list length = free blocks minus the never-used ones
      unused = (n > pool_fresh) ? n - pool_fresh : '0;
      listed = (pool_free > unused) ? pool_free - unused : '0;
      if (pool_head != HEAD_EMPTY) begin
        idx = pool_head;
        // last entry on the list: its link is not followed
        pool_head = (listed >= CNT_W'(2)) ? {1'b0, next_link[idx[IDX_W-1:0]]} : HEAD_EMPTY;
        r.granted = 1'b1;
      end else if (pool_fresh < n) begin
        idx = pool_fresh;
        pool_fresh = pool_fresh + CNT_W'(1);
        r.granted = 1'b1;
      end
      if (r.granted && pool_free != '0) pool_free = pool_free - CNT_W'(1);
    end else begin
      if (pool_free >= n) begin
        r.overflow_error = 1'b1;
      end else if (CNT_W'(req.block_in) < n) begin
        next_link[req.block_in] = (pool_head != HEAD_EMPTY) ? pool_head[IDX_W-1:0] : '0;
        pool_head = CNT_W'(req.block_in);
        pool_free = pool_free + CNT_W'(1);
      end
      // out-of-range release: silently dropped
    end
    if (r.granted) begin
      ofs           = 32'(idx) * 32'(cfg_chunk);
      r.block_out   = idx[IDX_W-1:0];
      r.byte_offset = ofs[OFS_W-1:0];
    end
    r.free_left = pool_free;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Error reporting and response monitor
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  out_item_t want_r;
  out_item_t got_r;

  // a response moves at an edge with valid high and stall low
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (resp_due.size() == 0) begin
        flag_error("response with no request outstanding");
      end else begin
        want_r = resp_due.pop_front();
        got_r  = out_item_o;
        check_field("granted",        32'(got_r.granted),        32'(want_r.granted));
        check_field("block_out",      32'(got_r.block_out),      32'(want_r.block_out));
        check_field("byte_offset",    32'(got_r.byte_offset),    32'(want_r.byte_offset));
        check_field("free_left",      32'(got_r.free_left),      32'(want_r.free_left));
        check_field("overflow_error", 32'(got_r.overflow_error), 32'(want_r.overflow_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random stall bursts between clear stretches.
  // A long hold-off overrides everything; steady mode never stalls.
  // ---------------------------------------------------------------------------
  int unsigned stall_run = 0;
  int unsigned clear_run = 0;
  int unsigned hold_cnt  = 0;

  always @(posedge clk_i) begin
    if (long_hold) begin
      out_stall_i <= 1'b1;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) begin
        long_hold = 1'b0;
        hold_cnt  = 0;
      end
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else if (stall_run != 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if (clear_run != 0) begin
      out_stall_i <= 1'b0;
      clear_run--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      stall_run = $urandom_range(0, 18);
    end else begin
      out_stall_i <= 1'b0;
      clear_run = $urandom_range(0, 60);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one request per call. Valid stays high after acceptance so that
  // back-to-back items need no extra edge; wait_idle drops it.
  // ---------------------------------------------------------------------------
  task automatic send_req(input logic kind, input logic [IDX_W-1:0] blk);
    in_item_t    it;
    out_item_t   resp;
    int unsigned gap;
    it.kind     = kind;
    it.block_in = blk;
    if (!steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    resp = alloc_predict(it);
    resp_due.push_back(resp);
    if (resp.granted) held.push_back(resp.block_out);
  endtask

  // drop valid, wait for every response, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (resp_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access; pready is sampled on the access edge
  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_BLOCK_COUNT) begin
      cfg_blocks = val[CNT_W-1:0];
      pool_rebuild();
    end else begin
      cfg_chunk = val[CHUNK_W-1:0];
    end
  endtask

  // only while idle; a block_count write re-creates the pool
  task automatic reconfigure(input logic [31:0] blocks_val, input logic [31:0] chunk_val);
    wait_idle();
    reg_write(REG_BLOCK_COUNT, blocks_val);
    reg_write(REG_CHUNK_BYTES, chunk_val);
    held.delete();
  endtask

  // Mostly legal traffic: allocations and releases of blocks actually held.
  // About one item in ten is a stray release (double free, out of range).
  task automatic run_mix(input int unsigned n_items, input int unsigned alloc_pct);
    int unsigned      k;
    int unsigned      roll;
    int unsigned      pick;
    logic [IDX_W-1:0] blk;
    for (k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        send_req(KIND_ALLOC, IDX_W'($urandom));
      end else if (roll < 90 && held.size() != 0) begin
        pick = $urandom_range(0, held.size() - 1);
        blk  = held[pick];
        held.delete(pick);
        send_req(KIND_RELEASE, blk);
      end else begin
        send_req(KIND_RELEASE, IDX_W'($urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values, empty and full pool, list order, double free, clamping, wrap
  task automatic test_directed();
    int unsigned k;
    // reset config: 256 blocks of 1024 bytes
    send_req(KIND_ALLOC, 8'h00);
    send_req(KIND_RELEASE, 8'hFF);       // pushes 255 onto the list
    send_req(KIND_ALLOC, 8'h00);         // pops 255, offset 255 * 1024

    reconfigure(32'd4, 32'd65536);
    send_req(KIND_RELEASE, 8'd2);        // pool full -> overflow flag
    for (k = 0; k < 4; k++) send_req(KIND_ALLOC, 8'($urandom));
    send_req(KIND_ALLOC, 8'h00);         // pool empty -> refused
    send_req(KIND_RELEASE, 8'd200);      // out of range -> dropped
    send_req(KIND_RELEASE, 8'd1);
    send_req(KIND_RELEASE, 8'd3);
    send_req(KIND_ALLOC, 8'h00);         // LIFO: 3 first
    send_req(KIND_ALLOC, 8'h00);         // then 1, list now empty
    send_req(KIND_RELEASE, 8'd0);
    send_req(KIND_RELEASE, 8'd0);        // double free, not detected
    send_req(KIND_ALLOC, 8'h00);
    send_req(KIND_ALLOC, 8'h00);

    // zero block count acts as one block, zero chunk gives zero offsets
    reconfigure(32'd0, 32'd0);
    send_req(KIND_ALLOC, 8'hFF);
    send_req(KIND_ALLOC, 8'h00);
    send_req(KIND_RELEASE, 8'd0);
    send_req(KIND_RELEASE, 8'd0);        // full again -> overflow

    // count clamps to 256; oversized chunk makes offsets wrap at 24 bits
    reconfigure(32'd511, 32'h1FFFF);
    send_req(KIND_ALLOC, 8'h00);
    send_req(KIND_RELEASE, 8'hFF);
    send_req(KIND_ALLOC, 8'h00);
    send_req(KIND_ALLOC, 8'hFF);
  endtask

  // fill the block while the output is held off, then a full drain pause
  task automatic test_backpressure();
    int unsigned k;
    reconfigure(32'd16, 32'd100);
    long_hold = 1'b1;
    for (k = 0; k < 12; k++)
      send_req((k % 3 == 2) ? KIND_RELEASE : KIND_ALLOC, IDX_W'(k));
    run_mix(15, 60);
    wait_idle();                         // sender pauses until all responses are back
    run_mix(15, 40);
  endtask

  // several pool shapes, alternating fill-heavy and drain-heavy traffic
  task automatic test_random();
    reconfigure(32'd1, 32'd1);
    run_mix(20, 60);
    run_mix(20, 30);
    reconfigure(32'd2, 32'd65536);
    run_mix(20, 70);
    run_mix(20, 30);
    // junk in the upper data bits must be dropped by the registers
    reconfigure({23'h55AAFF, 9'd5}, {15'h7FFF, 17'($urandom)});
    run_mix(30, 65);
    run_mix(30, 30);
    // deep run: walks far into the never-used indexes
    reconfigure(32'd256, 32'($urandom_range(1, 131071)));
    run_mix(200, 90);
    run_mix(60, 15);
    reconfigure(32'($urandom_range(3, 255)), 32'($urandom_range(0, 131071)));
    run_mix(30, 55);
    run_mix(30, 35);
  endtask

  // closing stretch with both sides running flat out
  task automatic test_steady();
    steady = 1'b1;
    reconfigure(32'd16, 32'd4096);
    run_mix(40, 70);
    run_mix(40, 35);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    out_stall_i <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cfg_blocks  = BLOCK_COUNT_RESET;
    cfg_chunk   = CHUNK_BYTES_RESET;
    pool_rebuild();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random();
    test_steady();

    wait_idle();
    repeat (6) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
